[src/dlefd_pkg.sv]
`default_nettype none
package dlefd_pkg;

  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 12;
  localparam int LIMIT_W = 13;
  localparam int KIND_W  = 3;

  localparam logic [BYTE_W-1:0]  SYNC_BYTE = 8'h10;
  localparam logic [BYTE_W-1:0]  END_BYTE  = 8'h03;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 13'd4096;
  localparam logic [LIMIT_W-1:0] LIMIT_MIN = 13'd3;

  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RAW     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EPH     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BITS    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_IONO    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TIME    = 3'd5;

  localparam logic [BYTE_W-1:0] ID_RAW  = 8'hf5;
  localparam logic [BYTE_W-1:0] ID_EPH  = 8'hf7;
  localparam logic [BYTE_W-1:0] ID_BITS = 8'he5;
  localparam logic [BYTE_W-1:0] ID_IONO = 8'h4a;
  localparam logic [BYTE_W-1:0] ID_TIME = 8'h4b;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_DONE = 2'd1,
    ST_OVFL = 2'd2
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              frame_end;
    status_t           frame_status;
    logic [KIND_W-1:0] message_kind;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } push_t;

  function automatic logic [KIND_W-1:0] kind_of(input logic [BYTE_W-1:0] id);
    logic [KIND_W-1:0] k;
    case (id)
      ID_RAW:  k = KIND_RAW;
      ID_EPH:  k = KIND_EPH;
      ID_BITS: k = KIND_BITS;
      ID_IONO: k = KIND_IONO;
      ID_TIME: k = KIND_TIME;
      default: k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

[src/dlefd_if.sv]
`default_nettype none
interface dlefd_in_if
  import dlefd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dlefd_out_if
  import dlefd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic [IDX_W-1:0]  byte_index;
  logic              frame_end;
  logic [1:0]        frame_status;
  logic [KIND_W-1:0] message_kind;

  modport source (output valid, output frame_byte, output byte_index, output frame_end,
                  output frame_status, output message_kind, input ready);
  modport sink (input valid, input frame_byte, input byte_index, input frame_end,
                input frame_status, input message_kind, output ready);
endinterface
`default_nettype wire

[src/dlefd_deframe.sv]
`default_nettype none
module dlefd_deframe
  import dlefd_pkg::*;
#(
  parameter int MAX_FRAME = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [BYTE_W-1:0]  rx_byte,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  output push_t              push
);

  localparam int CNT_W = $clog2(MAX_FRAME);
  localparam int CMP_W = (CNT_W + 1 > LIMIT_W) ? CNT_W + 1 : LIMIT_W;
  localparam logic [CMP_W-1:0] MAX_LIM = CMP_W'(MAX_FRAME);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  logic [LIMIT_W-1:0] limit_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               parity_r, parity_nxt;
  logic [BYTE_W-1:0]  id_r, id_nxt;

  logic               is_sync, is_end, par_t;
  logic [CMP_W-1:0]   lim, lim_raw, inc;

  always_comb begin
    lim_raw = CMP_W'(limit_r);
    if (lim_raw < CMP_W'(LIMIT_MIN)) begin
      lim = CMP_W'(LIMIT_MIN);
    end else if (lim_raw > MAX_LIM) begin
      lim = MAX_LIM;
    end else begin
      lim = lim_raw;
    end
  end

  assign is_sync = (rx_byte == SYNC_BYTE);
  assign is_end  = (rx_byte == END_BYTE);
  assign par_t   = parity_r ^ is_sync;
  assign inc     = CMP_W'(count_r) + CMP_W'(1);

  always_comb begin
    count_nxt  = count_r;
    parity_nxt = parity_r;
    id_nxt     = id_r;
    push.valid = 1'b0;
    push.data.frame_byte   = rx_byte;
    push.data.byte_index   = IDX_W'(count_r);
    push.data.frame_end    = 1'b0;
    push.data.frame_status = ST_DATA;
    push.data.message_kind = KIND_UNKNOWN;
    if (fire) begin
      if (count_r == '0) begin
        if (is_sync) begin
          count_nxt  = CNT_ONE;
          push.valid = 1'b1;
        end
      end else if (count_r == CNT_ONE) begin
        if (is_sync || is_end) begin
          count_nxt = '0;
        end else begin
          id_nxt     = rx_byte;
          parity_nxt = 1'b0;
          count_nxt  = CNT_TWO;
          push.valid = 1'b1;
        end
      end else if (is_sync && !par_t) begin
        parity_nxt = 1'b0;
      end else begin
        push.valid = 1'b1;
        if (is_end && par_t) begin
          count_nxt  = '0;
          parity_nxt = 1'b0;
          push.data.frame_end    = 1'b1;
          push.data.frame_status = ST_DONE;
          push.data.message_kind = kind_of(id_r);
        end else if (inc >= lim) begin
          count_nxt  = '0;
          parity_nxt = 1'b0;
          push.data.frame_end    = 1'b1;
          push.data.frame_status = ST_OVFL;
        end else begin
          count_nxt  = inc[CNT_W-1:0];
          parity_nxt = par_t;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RST;
      count_r  <= '0;
      parity_r <= 1'b0;
      id_r     <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      count_r  <= count_nxt;
      parity_r <= parity_nxt;
      id_r     <= id_nxt;
    end
  end

endmodule
`default_nettype wire

[src/dlefd_skid.sv]
`default_nettype none
module dlefd_skid
  import dlefd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    push_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_v_r, skid_v_r;
  result_t main_r, skid_r;

  assign push_ready = !skid_v_r;
  assign out_valid  = main_v_r;
  assign out_data   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        main_v_r <= push.valid;
      end
    end else if (push.valid) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || out_ready) begin
      main_r <= skid_v_r ? skid_r : push.data;
    end else if (push.valid && !skid_v_r) begin
      skid_r <= push.data;
    end
  end

endmodule
`default_nettype wire

[src/dle_etx_frame_deframer.sv]
// channel  dir  payload                                                      accepted when
// in_if    in   rx_byte                                                      valid && ready
// out_if   out  frame_byte byte_index frame_end frame_status message_kind    valid && ready
// cfg      in   cfg_wdata (frame_limit)                                      cfg_we
//
// one byte a cycle while in_if is ready; a stored byte is registered in the output buffer
// frame state updates in the cycle a byte is taken, so bytes run back to back
// a two-entry output buffer keeps in_if ready until both of its entries hold data
// synchronous active-low reset: hunting, limit 4096, output buffer empty
`default_nettype none
module dle_etx_frame_deframer
  import dlefd_pkg::*;
#(
  parameter int MAX_FRAME = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  dlefd_in_if.sink           in_if,
  dlefd_out_if.source        out_if,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  push_t   push;
  result_t res;
  logic    fire;

  assign fire = in_if.valid && in_if.ready;

  dlefd_deframe #(
    .MAX_FRAME(MAX_FRAME)
  ) u_deframe (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .rx_byte  (in_if.rx_byte),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .push     (push)
  );

  dlefd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ready(in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (res)
  );

  assign out_if.frame_byte   = res.frame_byte;
  assign out_if.byte_index   = res.byte_index;
  assign out_if.frame_end    = res.frame_end;
  assign out_if.frame_status = res.frame_status;
  assign out_if.message_kind = res.message_kind;

  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> out_if.valid)
    else $error("input stalled with empty output");

  a_end_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.frame_end == (out_if.frame_status != ST_DATA)))
    else $error("frame_end disagrees with frame_status");

  a_kind_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.message_kind != KIND_UNKNOWN) |-> out_if.frame_status == ST_DONE)
    else $error("message kind outside a completed frame");

  a_sync_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (MAX_FRAME <= 4096) && out_if.valid && (out_if.byte_index == '0)
      |-> out_if.frame_byte == SYNC_BYTE)
    else $error("byte zero is not a sync byte");

endmodule
`default_nettype wire
